// File: sv/gcr_pkg.sv
// ============================================================================
// gcr_pkg: shared types and constants for the glyph column rasterizer
// Holds the word layouts of both channels, the configuration set, the
// controller states and the command and status groups between the modules.
// ============================================================================
package gcr_pkg;

    // Fixed field widths
    localparam int COORD_W    = 10;
    localparam int WIDTH_W    = 5;
    localparam int HEIGHT_W   = 3;
    localparam int ROW_W      = 2;
    localparam int MAX_HEIGHT = 4;
    localparam int INDEX_W    = 12;
    localparam int CODE_W     = 8;
    localparam int BYTE_W     = 8;
    localparam int COLOUR_W   = 2;
    localparam int LENGTH_W   = 13;

    // Offset arithmetic: covers the largest store and the largest offset sum
    localparam int OFS_W = 17;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Default sizes
    localparam int GLYPH_COUNT_DEF = 128;
    localparam int FONT_BYTES_DEF  = 4096;
    localparam int MAX_WIDTH_DEF   = 16;

    // Input actions
    typedef enum logic [1:0] {
        ACT_LOAD_WIDTH  = 2'd0,
        ACT_LOAD_FONT   = 2'd1,
        ACT_DRAW_POS    = 2'd2,
        ACT_DRAW_CURSOR = 2'd3
    } action_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_CODE   = 3'd0,
        CFG_HEIGHT_BYTES = 3'd1,
        CFG_FONT_LENGTH  = 3'd2,
        CFG_BYTE_ORDER   = 3'd3,
        CFG_INVERT_BITS  = 3'd4,
        CFG_INK_COLOUR   = 3'd5
    } cfg_index_t;

    // Reset values of the configuration registers
    localparam logic [CODE_W-1:0]   FIRST_CODE_RST   = 8'd32;
    localparam logic [HEIGHT_W-1:0] HEIGHT_BYTES_RST = 3'd1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_CHECK,
        ST_FETCH,
        ST_EMIT
    } ctrl_state_t;

    // Input word
    typedef struct packed {
        action_t               action;
        logic [INDEX_W-1:0]    table_index;
        logic [BYTE_W-1:0]     table_data;
        logic [CODE_W-1:0]     char_code;
        logic [COORD_W-1:0]    pos_x;
        logic [COORD_W-1:0]    pos_y;
    } gcr_in_t;

    // Output word
    typedef struct packed {
        logic [COORD_W-1:0]    out_x;
        logic [COORD_W-1:0]    out_y;
        logic [BYTE_W-1:0]     pixel_mask;
        logic [COLOUR_W-1:0]   pixel_colour;
        logic                  last;
    } gcr_out_t;

    // Configuration set
    typedef struct packed {
        logic [CODE_W-1:0]     first_code;
        logic [HEIGHT_W-1:0]   height_bytes;
        logic [LENGTH_W-1:0]   font_length;
        logic                  byte_order_forward;
        logic                  invert_bits;
        logic [COLOUR_W-1:0]   ink_colour;
    } gcr_cfg_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic start_draw;
        logic walk_step;
        logic check;
        logic fetch;
        logic load_out;
    } gcr_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic draw_ok;
        logic walk_at_target;
        logic glyph_empty;
        logic glyph_fits;
        logic pend_last;
        logic out_free;
    } gcr_status_t;

endpackage

// File: sv/gcr_ctrl.sv
// ============================================================================
// gcr_ctrl: sequencing controller of the glyph column rasterizer
// Steps a draw through the width walk, the bounds check and the byte
// emission loop, and accepts a new word only while idle.
// ============================================================================
module gcr_ctrl
    import gcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  gcr_status_t status,
    output gcr_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.draw_ok)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (status.walk_at_target)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.glyph_empty || !status.glyph_fits)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free && status.pend_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall       = 1'b0;
                cmd.accept     = in_valid;
                cmd.start_draw = in_valid && status.draw_ok;
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.fetch    = !status.pend_last;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// File: sv/gcr_datapath.sv
// ============================================================================
// gcr_datapath: storage and arithmetic of the glyph column rasterizer
// Keeps the width table and the font store, sums the offset of a glyph,
// walks its bytes column by column and holds the output word.
// ============================================================================
module gcr_datapath
    import gcr_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int FONT_BYTES  = FONT_BYTES_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  gcr_cfg_t    cfg,
    input  gcr_in_t     in_data,
    input  gcr_cmd_t    cmd,
    output gcr_status_t status,
    output logic        out_valid,
    input  logic        out_stall,
    output gcr_out_t    out_data
);

    localparam int GW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int FW = $clog2(FONT_BYTES);
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // Stores
    logic [WIDTH_W-1:0]  width_mem [GLYPH_COUNT];
    logic [BYTE_W-1:0]   font_mem  [FONT_BYTES];

    // Walk and glyph state
    logic [GW-1:0]       idx_reg;
    logic [GW-1:0]       walk_cnt_reg;
    logic                walk_prev_reg;
    logic [OFS_W-1:0]    start_reg;
    logic [WIDTH_W-1:0]  width_rd_reg;
    logic [COORD_W-1:0]  cursor_x_reg;
    logic [COORD_W-1:0]  cursor_y_reg;
    logic [COORD_W-1:0]  base_x_reg;
    logic [COORD_W-1:0]  base_y_reg;
    logic [WIDTH_W-1:0]  glyph_w_reg;
    logic [OFS_W-1:0]    col_base_reg;
    logic [CW-1:0]       col_reg;
    logic [ROW_W-1:0]    row_reg;

    // Fetched byte and its coordinates
    logic [BYTE_W-1:0]   font_rd_reg;
    logic [COORD_W-1:0]  meta_x_reg;
    logic [COORD_W-1:0]  meta_y_reg;
    logic                meta_last_reg;

    // Output register
    logic                out_valid_reg;
    gcr_out_t            out_data_reg;

    // Combinational values
    logic [OFS_W-1:0]               tindex_ext;
    logic [WIDTH_W-1:0]             width_sat;
    logic [HEIGHT_W-1:0]            eff_h;
    logic [CODE_W-1:0]              idx_full;
    logic                           is_draw;
    logic [WIDTH_W+HEIGHT_W-1:0]    prod;
    logic [OFS_W-1:0]               end_ofs;
    logic [OFS_W-1:0]               len_eff;
    logic [HEIGHT_W-1:0]            row_off;
    logic [OFS_W-1:0]               font_addr;
    logic                           row_end;
    logic                           is_last;
    logic                           width_we;
    logic                           font_we;

    // Input decode and effective height
    always_comb
    begin
        tindex_ext = OFS_W'(in_data.table_index);
        width_sat  = (in_data.table_data > BYTE_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH)
                                                                : in_data.table_data[WIDTH_W-1:0];
        eff_h      = (cfg.height_bytes > HEIGHT_W'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT)
                                                                 : cfg.height_bytes;
        idx_full   = in_data.char_code - cfg.first_code;
        is_draw    = (in_data.action == ACT_DRAW_POS) || (in_data.action == ACT_DRAW_CURSOR);
        width_we   = cmd.accept && (in_data.action == ACT_LOAD_WIDTH)
                     && (tindex_ext < OFS_W'(GLYPH_COUNT));
        font_we    = cmd.accept && (in_data.action == ACT_LOAD_FONT)
                     && (tindex_ext < OFS_W'(FONT_BYTES));
    end

    // Glyph size and bounds
    always_comb
    begin
        prod    = width_rd_reg * eff_h;
        end_ofs = start_reg + OFS_W'(prod);
        len_eff = (OFS_W'(cfg.font_length) > OFS_W'(FONT_BYTES)) ? OFS_W'(FONT_BYTES)
                                                                 : OFS_W'(cfg.font_length);
    end

    // Byte address and position inside the glyph
    always_comb
    begin
        row_off   = cfg.byte_order_forward ? HEIGHT_W'(row_reg)
                                           : (eff_h - 3'd1 - HEIGHT_W'(row_reg));
        font_addr = col_base_reg + OFS_W'(row_off);
        row_end   = (HEIGHT_W'(row_reg) == (eff_h - 3'd1));
        is_last   = row_end && (WIDTH_W'(col_reg) == (glyph_w_reg - 5'd1));
    end

    // Status toward the controller
    always_comb
    begin
        status.draw_ok        = is_draw && (in_data.char_code >= cfg.first_code)
                                && ({1'b0, idx_full} < (CODE_W + 1)'(GLYPH_COUNT))
                                && (eff_h != '0);
        status.walk_at_target = (walk_cnt_reg == idx_reg);
        status.glyph_empty    = (width_rd_reg == '0);
        status.glyph_fits     = (end_ofs <= len_eff);
        status.pend_last      = meta_last_reg;
        status.out_free       = !out_valid_reg || !out_stall;
    end

    // Width table: load writes and the walk read
    always_ff @(posedge clk)
    begin
        if (width_we)
        begin
            width_mem[tindex_ext[GW-1:0]] <= width_sat;
        end
        if (cmd.walk_step)
        begin
            width_rd_reg <= width_mem[walk_cnt_reg];
        end
    end

    // Font store: load writes and the emission read
    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            font_mem[tindex_ext[FW-1:0]] <= in_data.table_data;
        end
        if (cmd.fetch)
        begin
            font_rd_reg <= font_mem[font_addr[FW-1:0]];
        end
    end

    // Offset walk: each step adds the previous glyph's byte count
    always_ff @(posedge clk)
    begin
        if (cmd.start_draw)
        begin
            idx_reg      <= idx_full[GW-1:0];
            walk_cnt_reg <= '0;
            start_reg    <= '0;
        end
        else if (cmd.walk_step)
        begin
            walk_cnt_reg <= walk_cnt_reg + 1'b1;
            if (walk_prev_reg)
            begin
                start_reg <= end_ofs;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_prev_reg <= 1'b0;
        end
        else if (cmd.start_draw)
        begin
            walk_prev_reg <= 1'b0;
        end
        else if (cmd.walk_step)
        begin
            walk_prev_reg <= 1'b1;
        end
    end

    // Cursor: set by a positioned draw, advanced by every non-empty glyph
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end
        else if (cmd.accept && (in_data.action == ACT_DRAW_POS))
        begin
            cursor_x_reg <= in_data.pos_x;
            cursor_y_reg <= in_data.pos_y;
        end
        else if (cmd.check && !status.glyph_empty)
        begin
            cursor_x_reg <= cursor_x_reg + COORD_W'(width_rd_reg);
        end
    end

    // Byte walk over columns and row groups
    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            base_x_reg   <= cursor_x_reg;
            base_y_reg   <= cursor_y_reg;
            glyph_w_reg  <= width_rd_reg;
            col_base_reg <= start_reg;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else if (cmd.fetch)
        begin
            meta_x_reg    <= base_x_reg + COORD_W'(col_reg);
            meta_y_reg    <= base_y_reg + COORD_W'({row_reg, 3'b000});
            meta_last_reg <= is_last;
            if (row_end)
            begin
                row_reg      <= '0;
                col_reg      <= col_reg + 1'b1;
                col_base_reg <= col_base_reg + OFS_W'(eff_h);
            end
            else
            begin
                row_reg <= row_reg + 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg.out_x        <= meta_x_reg;
            out_data_reg.out_y        <= meta_y_reg;
            out_data_reg.pixel_mask   <= font_rd_reg ^ {BYTE_W{cfg.invert_bits}};
            out_data_reg.pixel_colour <= cfg.ink_colour;
            out_data_reg.last         <= meta_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A word is only loaded when the output slot is free or being emptied.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("output word loaded over a waiting word");

    // Every font read lies inside the region that passed the bounds check.
    a_fetch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch |-> (font_addr < len_eff))
        else $error("font read beyond valid length");

    // The offset walk never runs past the target glyph.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> (walk_cnt_reg <= idx_reg))
        else $error("width walk past target glyph");

    // A non-empty glyph moves the cursor by exactly its width.
    a_cursor_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.check && !status.glyph_empty)
        |=> (cursor_x_reg == $past(cursor_x_reg + COORD_W'(width_rd_reg))))
        else $error("cursor advance mismatch");

endmodule

// File: sv/glyph_column_rasterizer.sv
// ============================================================================
// glyph_column_rasterizer: variable-width bitmap font character generator
// Loads glyph widths and column-major font bytes, then draws a glyph as one
// 8-row pixel mask word per font byte, advancing a text cursor.
// ============================================================================
// Sequence: a load word is taken while idle. A draw of glyph number g walks the
//   width table from glyph zero up to g, passes a check state and a fetch state,
//   then emits its words, one word per cycle while the output does not stall.
// Input: a draw holds the input stalled until its last word is loaded or its
//   check fails; the walk reads one width per cycle from the table.
// Reset: configuration returns to defaults and the cursor to zero; the width
//   table and font store keep their contents and are not cleared.
module glyph_column_rasterizer
    import gcr_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int FONT_BYTES  = FONT_BYTES_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  gcr_in_t                 in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output gcr_out_t                out_data,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    gcr_cfg_t    cfg_reg;
    gcr_cmd_t    cmd;
    gcr_status_t status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_code         <= FIRST_CODE_RST;
            cfg_reg.height_bytes       <= HEIGHT_BYTES_RST;
            cfg_reg.font_length        <= '0;
            cfg_reg.byte_order_forward <= 1'b1;
            cfg_reg.invert_bits        <= 1'b0;
            cfg_reg.ink_colour         <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIRST_CODE:   cfg_reg.first_code         <= cfg_data[CODE_W-1:0];
                CFG_HEIGHT_BYTES: cfg_reg.height_bytes       <= cfg_data[HEIGHT_W-1:0];
                CFG_FONT_LENGTH:  cfg_reg.font_length        <= cfg_data[LENGTH_W-1:0];
                CFG_BYTE_ORDER:   cfg_reg.byte_order_forward <= cfg_data[0];
                CFG_INVERT_BITS:  cfg_reg.invert_bits        <= cfg_data[0];
                CFG_INK_COLOUR:   cfg_reg.ink_colour         <= cfg_data[COLOUR_W-1:0];
                default:          cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // Controller
    gcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    gcr_datapath #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .FONT_BYTES  (FONT_BYTES),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: dv/tb_glyph_column_rasterizer.sv
// ============================================================================
// tb_glyph_column_rasterizer: self-checking bench for the glyph rasterizer
// Loads the first glyph widths and the first font bytes, walks a short
// directed plan, then runs random load and string-draw words under six
// register settings. Each input word is scored by a predictor of the mask
// words the block must produce, and every output word is checked field by field.
// ============================================================================
module tb_glyph_column_rasterizer;
    import gcr_pkg::*;

    // Clock period halves, quiet time before a register write, run limit
    localparam int HALF_PERIOD  = 4;
    localparam int SETTLE       = GLYPH_COUNT_DEF + 32;
    localparam int RUN_LIMIT    = 20_000_000;
    localparam int PHASE_WORDS  = 18;

    // Loaded part of the tables: draws only reach glyphs below WIDTH_FILL,
    // and every font length of the random phases stays at or below FONT_FILL.
    localparam int WIDTH_FILL   = 8;
    localparam int FONT_FILL    = 48;

    // One row of the directed plan: a register write or an input word.
    // A typed row carries its expected output instead of a predicted one.
    typedef struct packed {
        logic                  is_reg;
        cfg_index_t            reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        gcr_in_t               word;
        logic                  typed;
        logic                  typed_has_word;
        gcr_out_t              typed_word;
    } plan_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    gcr_in_t               in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    gcr_out_t              out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor state: tables, cursor and register copies
    logic [WIDTH_W-1:0]  glyph_width [GLYPH_COUNT_DEF];
    logic [BYTE_W-1:0]   font_bytes  [FONT_BYTES_DEF];
    logic [COORD_W-1:0]  cur_x       = '0;
    logic [COORD_W-1:0]  cur_y       = '0;
    logic [CODE_W-1:0]   cfg_first   = FIRST_CODE_RST;
    logic [HEIGHT_W-1:0] cfg_height  = HEIGHT_BYTES_RST;
    logic [LENGTH_W-1:0] cfg_length  = '0;
    logic                cfg_forward = 1'b1;
    logic                cfg_invert  = 1'b0;
    logic [COLOUR_W-1:0] cfg_ink     = '0;

    gcr_out_t    pending_masks [$];
    gcr_out_t    oldest_mask;
    plan_row_t   plan [$];
    int          mismatches    = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    glyph_column_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock
    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Run limit: a hung handshake or a lost mask word ends here.
    initial
    begin
        #(RUN_LIMIT);
        $display("glyph_column_rasterizer: mismatch");
        $finish;
    end

    // Predict the mask words of one glyph draw at the current cursor.
    function automatic void rasterize_glyph(input logic [CODE_W-1:0] code);
        int unsigned rows, glyph, base, cols, limit, addr, c, b;
        gcr_out_t    word;
        rows = (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
        if (code < cfg_first)
            return;
        glyph = code - cfg_first;
        if (glyph >= GLYPH_COUNT_DEF || rows == 0)
            return;
        // The glyph starts after all bytes of the earlier glyphs.
        base = 0;
        for (c = 0; c < glyph; c++)
            base += glyph_width[c] * rows;
        cols = glyph_width[glyph];
        if (cols == 0)
            return;
        limit = (cfg_length > FONT_BYTES_DEF) ? FONT_BYTES_DEF : cfg_length;
        if (base + cols * rows <= limit)
        begin
            for (c = 0; c < cols; c++)
            begin
                for (b = 0; b < rows; b++)
                begin
                    addr = base + c * rows + (cfg_forward ? b : rows - 1 - b);
                    word.out_x        = COORD_W'(cur_x + c);
                    word.out_y        = COORD_W'(cur_y + 8 * b);
                    word.pixel_mask   = font_bytes[addr] ^ {BYTE_W{cfg_invert}};
                    word.pixel_colour = cfg_ink;
                    word.last         = (c == cols - 1 && b == rows - 1);
                    pending_masks.push_back(word);
                end
            end
        end
        // A glyph past the font still moves the cursor.
        cur_x = COORD_W'(cur_x + cols);
    endfunction

    // Apply one accepted input word to the predictor.
    function automatic void rasterize_word(input gcr_in_t w);
        case (w.action)
            ACT_LOAD_WIDTH:
                if (w.table_index < GLYPH_COUNT_DEF)
                    glyph_width[w.table_index] = (w.table_data > MAX_WIDTH_DEF) ?
                        WIDTH_W'(MAX_WIDTH_DEF) : WIDTH_W'(w.table_data);
            ACT_LOAD_FONT:
                if (w.table_index < FONT_BYTES_DEF)
                    font_bytes[w.table_index] = w.table_data;
            ACT_DRAW_POS:
            begin
                cur_x = w.pos_x;
                cur_y = w.pos_y;
                rasterize_glyph(w.char_code);
            end
            default:
                rasterize_glyph(w.char_code);
        endcase
    endfunction

    // Mirror a register write into the predictor's copy.
    function automatic void track_register(input cfg_index_t idx,
                                           input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_FIRST_CODE:   cfg_first   = val[CODE_W-1:0];
            CFG_HEIGHT_BYTES: cfg_height  = val[HEIGHT_W-1:0];
            CFG_FONT_LENGTH:  cfg_length  = val[LENGTH_W-1:0];
            CFG_BYTE_ORDER:   cfg_forward = val[0];
            CFG_INVERT_BITS:  cfg_invert  = val[0];
            CFG_INK_COLOUR:   cfg_ink     = val[COLOUR_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic gcr_in_t mk_word(input action_t act, input int idx, input int data,
                                        input int code, input int x, input int y);
        gcr_in_t w;
        w.action      = act;
        w.table_index = INDEX_W'(idx);
        w.table_data  = BYTE_W'(data);
        w.char_code   = CODE_W'(code);
        w.pos_x       = COORD_W'(x);
        w.pos_y       = COORD_W'(y);
        return w;
    endfunction

    function automatic plan_row_t reg_row(input cfg_index_t idx, input int val);
        plan_row_t r;
        r         = '0;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = CFG_DATA_W'(val);
        return r;
    endfunction

    // Word whose output comes from the predictor
    function automatic plan_row_t item_row(input gcr_in_t w);
        plan_row_t r;
        r      = '0;
        r.word = w;
        return r;
    endfunction

    // Word that must give no output at all
    function automatic plan_row_t quiet_row(input gcr_in_t w);
        plan_row_t r;
        r       = '0;
        r.word  = w;
        r.typed = 1'b1;
        return r;
    endfunction

    // Word that must give exactly one mask word, flagged last
    function automatic plan_row_t one_row(input gcr_in_t w, input int x, input int y,
                                          input int mask, input int colour);
        plan_row_t r;
        r                = '0;
        r.word           = w;
        r.typed          = 1'b1;
        r.typed_has_word = 1'b1;
        r.typed_word     = {COORD_W'(x), COORD_W'(y), BYTE_W'(mask),
                            COLOUR_W'(colour), 1'b1};
        return r;
    endfunction

    // Character codes mostly on the loaded glyphs; the others fall below
    // the first code or past the glyph table, so they draw nothing.
    function automatic logic [CODE_W-1:0] pick_code();
        int unsigned code;
        code = $urandom_range(255, 0);
        if (($urandom_range(3, 0) != 0)
            || ((code >= cfg_first) && (code - cfg_first < GLYPH_COUNT_DEF)))
            code = cfg_first + $urandom_range(WIDTH_FILL - 1, 0);
        return CODE_W'(code);
    endfunction

    // Random word: mostly string draws, some table reloads, all bits toggled
    function automatic gcr_in_t random_word();
        logic [63:0] raw;
        gcr_in_t     w;
        int unsigned pick;
        raw  = {$urandom, $urandom};
        w    = gcr_in_t'(raw[$bits(gcr_in_t)-1:0]);
        pick = $urandom_range(99, 0);
        if (pick < 12)
        begin
            w.action = ACT_LOAD_WIDTH;
            if ($urandom_range(4, 0) != 0)
                w.table_index = INDEX_W'($urandom_range(WIDTH_FILL - 1, 0));
            if ($urandom_range(3, 0) != 0)
                w.table_data = BYTE_W'($urandom_range(3, 0));
        end
        else if (pick < 22)
            w.action = ACT_LOAD_FONT;
        else if (pick < 37)
        begin
            w.action    = ACT_DRAW_POS;
            w.char_code = pick_code();
        end
        else
        begin
            w.action    = ACT_DRAW_CURSOR;
            w.char_code = pick_code();
        end
        return w;
    endfunction

    // Send one word, then record what it must produce.
    task automatic send_word(input gcr_in_t w, input logic typed,
                             input logic has_one, input gcr_out_t one);
        int unsigned mark;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        mark = pending_masks.size();
        rasterize_word(w);
        if (typed)
        begin
            while (pending_masks.size() > mark)
                pending_masks.delete(pending_masks.size() - 1);
            if (has_one)
                pending_masks.push_back(one);
        end
    endtask

    // Wait until all mask words are out and a draw with no output is done.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_masks.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        track_register(idx, val);
    endtask

    task automatic apply_setting(input gcr_cfg_t s);
        write_reg(CFG_FIRST_CODE,   CFG_DATA_W'(s.first_code));
        write_reg(CFG_HEIGHT_BYTES, CFG_DATA_W'(s.height_bytes));
        write_reg(CFG_FONT_LENGTH,  CFG_DATA_W'(s.font_length));
        write_reg(CFG_BYTE_ORDER,   CFG_DATA_W'(s.byte_order_forward));
        write_reg(CFG_INVERT_BITS,  CFG_DATA_W'(s.invert_bits));
        write_reg(CFG_INK_COLOUR,   CFG_DATA_W'(s.ink_colour));
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Receiver: stall at the rate of the current phase
    always @(posedge clk)
        out_stall <= ($urandom_range(99, 0) < recv_idle_pct);

    // Score every accepted output word against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_masks.size() == 0)
            begin
                $display("%0t: unexpected word x=%0d y=%0d mask=%02h", $time,
                         out_data.out_x, out_data.out_y, out_data.pixel_mask);
                mismatches++;
            end
            else
            begin
                oldest_mask = pending_masks.pop_front();
                compare_field("out_x", 32'(oldest_mask.out_x), 32'(out_data.out_x));
                compare_field("out_y", 32'(oldest_mask.out_y), 32'(out_data.out_y));
                compare_field("pixel_mask", 32'(oldest_mask.pixel_mask),
                              32'(out_data.pixel_mask));
                compare_field("pixel_colour", 32'(oldest_mask.pixel_colour),
                              32'(out_data.pixel_colour));
                compare_field("last", 32'(oldest_mask.last), 32'(out_data.last));
            end
        end
    end

    // Main sequence
    initial
    begin
        gcr_cfg_t settings [6];
        int       i, p, n;

        // Register settings per phase: first code, height, length,
        // forward order, invert, ink
        settings[0] = {8'd32,  3'd1, 13'd48, 1'b1, 1'b0, 2'd0};
        settings[1] = {8'd0,   3'd4, 13'd48, 1'b0, 1'b1, 2'd3};
        settings[2] = {8'd128, 3'd2, 13'd40, 1'b1, 1'b1, 2'd1};
        settings[3] = {8'd64,  3'd3, 13'd30, 1'b0, 1'b0, 2'd2};
        settings[4] = {8'd255, 3'd4, 13'd47, 1'b1, 1'b0, 2'd3};
        settings[5] = {8'd200, 3'd3, 13'd36, 1'b0, 1'b1, 2'd2};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 13;
        recv_idle_pct = 81;

        // Fill the first glyph widths and font bytes. Draws never reach a
        // glyph past this part of the width table, and no glyph that fits the font
        // length runs past the filled bytes, so no draw reads an unwritten entry.
        for (i = 0; i < WIDTH_FILL; i++)
            send_word(mk_word(ACT_LOAD_WIDTH, i, 2, 0, 0, 0), 1'b0, 1'b0, '0);
        for (i = 0; i < FONT_FILL; i++)
            send_word(mk_word(ACT_LOAD_FONT, i, $urandom_range(255, 0), 0, 0, 0),
                      1'b0, 1'b0, '0);

        // Directed plan, starting from the reset register values
        plan.push_back(quiet_row(mk_word(ACT_DRAW_POS, 0, 0, 0, 0, 0)));
        plan.push_back(quiet_row(mk_word(ACT_DRAW_POS, 0, 0, 255, 1023, 1023)));
        // Empty font: nothing drawn, but the cursor moves on.
        plan.push_back(quiet_row(mk_word(ACT_DRAW_CURSOR, 0, 0, 32, 0, 0)));
        plan.push_back(item_row(mk_word(ACT_LOAD_WIDTH, 4095, 3, 0, 0, 0)));
        plan.push_back(item_row(mk_word(ACT_LOAD_WIDTH, 0, 1, 0, 0, 0)));
        plan.push_back(item_row(mk_word(ACT_LOAD_FONT, 0, 'hA5, 0, 0, 0)));
        plan.push_back(reg_row(CFG_FONT_LENGTH, 8191));
        // Single-byte glyph at the far corner, then the cursor wraps to zero.
        plan.push_back(one_row(mk_word(ACT_DRAW_POS, 0, 0, 32, 1023, 1023),
                               1023, 1023, 'hA5, 0));
        plan.push_back(one_row(mk_word(ACT_DRAW_CURSOR, 0, 0, 32, 0, 0),
                               0, 1023, 'hA5, 0));
        plan.push_back(reg_row(CFG_INVERT_BITS, 1));
        plan.push_back(reg_row(CFG_INK_COLOUR, 3));
        plan.push_back(one_row(mk_word(ACT_DRAW_POS, 0, 0, 32, 512, 256),
                               512, 256, 'h5A, 3));
        // Zero-width glyph
        plan.push_back(item_row(mk_word(ACT_LOAD_WIDTH, 0, 0, 0, 0, 0)));
        plan.push_back(quiet_row(mk_word(ACT_DRAW_POS, 0, 0, 32, 5, 5)));
        // Width above the maximum saturates; reversed bytes, both axes wrap.
        plan.push_back(item_row(mk_word(ACT_LOAD_WIDTH, 0, 255, 0, 0, 0)));
        plan.push_back(reg_row(CFG_HEIGHT_BYTES, 2));
        plan.push_back(reg_row(CFG_BYTE_ORDER, 0));
        plan.push_back(reg_row(CFG_INVERT_BITS, 0));
        plan.push_back(item_row(mk_word(ACT_DRAW_POS, 0, 0, 32, 1016, 1020)));
        plan.push_back(reg_row(CFG_HEIGHT_BYTES, 0));
        plan.push_back(quiet_row(mk_word(ACT_DRAW_CURSOR, 0, 0, 32, 0, 0)));
        // Height above four saturates; the glyph ends exactly on the last
        // valid byte of the font.
        plan.push_back(reg_row(CFG_HEIGHT_BYTES, 7));
        plan.push_back(item_row(mk_word(ACT_LOAD_WIDTH, 0, 8, 0, 0, 0)));
        plan.push_back(reg_row(CFG_FIRST_CODE, 0));
        plan.push_back(reg_row(CFG_FONT_LENGTH, 40));
        plan.push_back(item_row(mk_word(ACT_LOAD_FONT, 39, 'h81, 0, 0, 0)));
        plan.push_back(item_row(mk_word(ACT_DRAW_POS, 0, 0, 1, 0, 0)));
        // One byte short of the glyph, then a code past the table
        plan.push_back(reg_row(CFG_FONT_LENGTH, 39));
        plan.push_back(quiet_row(mk_word(ACT_DRAW_CURSOR, 0, 0, 1, 0, 0)));
        plan.push_back(quiet_row(mk_word(ACT_DRAW_CURSOR, 0, 0, 128, 0, 0)));

        foreach (plan[i])
        begin
            if (plan[i].is_reg)
            begin
                drain();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                send_word(plan[i].word, plan[i].typed, plan[i].typed_has_word,
                          plan[i].typed_word);
        end

        // Random phases: receiver mostly stalled, then sender mostly idle,
        // then full rate on both sides.
        for (p = 0; p < 6; p++)
        begin
            drain();
            send_idle_pct = (p < 2) ? 13 : (p < 4) ? 81 : 0;
            recv_idle_pct = (p < 2) ? 81 : (p < 4) ? 13 : 0;
            apply_setting(settings[p]);
            for (n = 0; n < PHASE_WORDS; n++)
                send_word(random_word(), 1'b0, 1'b0, '0);
        end

        drain();
        if (mismatches == 0)
            $display("glyph_column_rasterizer: match");
        else
            $display("glyph_column_rasterizer: mismatch");
        $finish;
    end

endmodule

// File: glyph_column_rasterizer.f
sv/gcr_pkg.sv
sv/gcr_ctrl.sv
sv/gcr_datapath.sv
sv/glyph_column_rasterizer.sv
dv/tb_glyph_column_rasterizer.sv
